[hdl/lcfs_pkg.sv]
// shared types, codes and constants for the color fade sequencer
package lcfs_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int DIV_W           = 32;
    localparam int ITER_W          = 6;
    localparam logic [DIV_W-1:0] SPEEDUP_BASE = 32'd100;
    // floor(x / 100) == (x * ceil(2^37 / 100)) >> 37 for every 32-bit x
    localparam int               SPEEDUP_SHIFT = 37;
    localparam logic [DIV_W-1:0] SPEEDUP_RECIP =
        32'(((64'd1 << SPEEDUP_SHIFT) + 64'(SPEEDUP_BASE) - 64'd1) / 64'(SPEEDUP_BASE));

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_LOAD  = 3'd1;
    localparam logic [2:0] REQ_START = 3'd2;
    localparam logic [2:0] REQ_STOP  = 3'd3;
    localparam logic [2:0] REQ_NEXT  = 3'd4;
    localparam logic [2:0] REQ_JUMP  = 3'd5;

    localparam logic [1:0] CFG_STEP_COUNT  = 2'd0;
    localparam logic [1:0] CFG_LOOP_ENABLE = 2'd1;
    localparam logic [1:0] CFG_SUNSET_MODE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_START_WB,
        ST_JUMP_WB,
        ST_ADV,
        ST_ADV_WB,
        ST_TICK_RD,
        ST_TICK_SETUP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUN_RD,
        ST_SUN_GO,
        ST_SUN_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [3:0]  entry_index;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [31:0] interval_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       running;
        logic [3:0] step_now;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [DIV_W-1:0]  quo_init;
        logic [DIV_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

[hdl/lcfs_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module lcfs_div
    import lcfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic [DIV_W:0]    trial;
    logic              ge;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.rem_init;
            quo_reg <= req.quo_init;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

[hdl/led_color_fade_sequencer_top.sv]
// top level of the rgb keyframe color fade sequencer
// a tick that blends works through 3 channels, each a multiply plus an
// 8-step serial divide; sunset stop walks the interval table, reading, scaling
// and writing back one entry per step
// throughput: one item at a time, the next is taken once the result is in the output register
// reset: async active low, light black, idle, step 0, step_count 1; tables undefined until loaded
module led_color_fade_sequencer_top
    import lcfs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // keyframe tables, one synchronous read port shared by both
    logic [23:0] tgt_mem [TABLE_DEPTH];
    logic [31:0] ivl_mem [TABLE_DEPTH];

    state_t state_reg, state_next;

    // latched item
    logic [2:0]  req_reg;
    logic [31:0] now_reg;
    logic [3:0]  idx_reg;
    logic [23:0] tgt_in_reg;
    logic [31:0] ivl_in_reg;

    // sequencer state
    logic [23:0] light_reg, light_next;
    logic [23:0] origin_reg, origin_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] end_reg, end_next;
    logic        active_reg, active_next;

    // configuration
    logic [4:0] count_reg;
    logic       loop_reg;
    logic       sunset_reg;

    // memory port
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             tgt_we;
    logic             ivl_we;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      ivl_wdata;
    logic [23:0]      tgt_q;
    logic [31:0]      ivl_q;

    // fade math scratch
    logic [31:0] d_reg, d_next;
    logic [31:0] e_reg, e_next;
    logic [23:0] tgt_reg, tgt_next;
    logic [1:0]  ch_reg, ch_next;
    logic [39:0] prod_reg, prod_next;
    logic        up_reg, up_next;
    logic [7:0]  org_b_reg, org_b_next;
    logic [4:0]  walk_reg, walk_next;
    logic [63:0] sun_prod_reg, sun_prod_next;

    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    logic      out_load;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // helpers
    logic [4:0]  eff;
    logic [5:0]  step_inc;
    logic        adv_wrap;
    logic        adv_stop;
    logic [4:0]  adv_step;
    logic        load_ok;
    logic        jump_ok;
    logic        in_acc;
    logic [31:0] d_cur;
    logic [31:0] e_raw;
    logic [7:0]  o_b;
    logic [7:0]  t_b;
    logic [7:0]  diff_b;
    logic [7:0]  blend_b;

    function automatic logic [IDX_W-1:0] tbl_idx(input logic [4:0] s);
        tbl_idx = (32'(s) < TABLE_DEPTH) ? IDX_W'(s) : '0;
    endfunction

    function automatic logic [7:0] byte_of(input logic [23:0] c, input logic [1:0] ch);
        logic [7:0] b;
        case (ch)
            2'd0:    b = c[23:16];
            2'd1:    b = c[15:8];
            default: b = c[7:0];
        endcase
        return b;
    endfunction

    lcfs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // step count clamped to the table depth
    assign eff      = (32'(count_reg) > TABLE_DEPTH) ? 5'(TABLE_DEPTH) : count_reg;
    assign step_inc = {1'b0, step_reg} + 6'd1;
    assign adv_wrap = step_inc >= {1'b0, eff};
    assign adv_stop = adv_wrap && !loop_reg;
    assign adv_step = adv_wrap ? 5'd0 : step_inc[4:0];
    assign load_ok  = 32'(idx_reg) < TABLE_DEPTH;
    assign jump_ok  = active_reg && ({1'b0, idx_reg} < eff);

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // fade arithmetic
    assign d_cur  = end_reg - start_reg;
    assign e_raw  = now_reg - start_reg;
    assign o_b    = byte_of(origin_reg, ch_reg);
    assign t_b    = byte_of(tgt_reg, ch_reg);
    assign diff_b = (t_b >= o_b) ? (t_b - o_b) : (o_b - t_b);
    // falling channels round the step away from the origin, i.e. ceiling of the quotient
    assign blend_b = up_reg ? (org_b_reg + div_rsp.quo[7:0])
                            : (org_b_reg - div_rsp.quo[7:0]
                               - {7'd0, (div_rsp.rem != '0)});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                case (req_reg)
                    REQ_START: state_next = ST_START_WB;
                    REQ_STOP:  state_next = (active_reg && sunset_reg) ? ST_SUN_RD : ST_DONE;
                    REQ_NEXT:  state_next = active_reg ? ST_ADV : ST_DONE;
                    REQ_JUMP:  state_next = jump_ok ? ST_JUMP_WB : ST_DONE;
                    REQ_TICK:
                    begin
                        if (!active_reg)
                            state_next = ST_DONE;
                        else if (now_reg > end_reg)
                            state_next = ST_ADV;
                        else
                            state_next = ST_TICK_RD;
                    end
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_START_WB:   state_next = ST_DONE;
            ST_JUMP_WB:    state_next = ST_DONE;
            ST_ADV:        state_next = adv_stop ? ST_DONE : ST_ADV_WB;
            ST_ADV_WB:     state_next = (req_reg == REQ_TICK) ? ST_TICK_RD : ST_DONE;
            ST_TICK_RD:    state_next = ST_TICK_SETUP;
            ST_TICK_SETUP: state_next = (d_cur == '0) ? ST_DONE : ST_MUL;
            ST_MUL:        state_next = ST_DIV_GO;
            ST_DIV_GO:     state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (ch_reg == 2'd2) ? ST_DONE : ST_MUL;
            end
            ST_SUN_RD:     state_next = (walk_reg >= eff) ? ST_ADV : ST_SUN_GO;
            ST_SUN_GO:     state_next = ST_SUN_WAIT;
            ST_SUN_WAIT:   state_next = ST_SUN_RD;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        light_next    = light_reg;
        origin_next   = origin_reg;
        step_next     = step_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        active_next   = active_reg;
        d_next        = d_reg;
        e_next        = e_reg;
        tgt_next      = tgt_reg;
        ch_next       = ch_reg;
        prod_next     = prod_reg;
        up_next       = up_reg;
        org_b_next    = org_b_reg;
        walk_next     = walk_reg;
        sun_prod_next = sun_prod_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        tgt_we        = 1'b0;
        ivl_we        = 1'b0;
        wr_addr       = IDX_W'(idx_reg);
        ivl_wdata     = ivl_in_reg;
        div_req       = '0;

        case (state_reg)
            ST_DISPATCH:
            begin
                case (req_reg)
                    REQ_LOAD:
                    begin
                        tgt_we = load_ok;
                        ivl_we = load_ok;
                    end
                    REQ_START:
                    begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                    REQ_STOP:
                    begin
                        if (active_reg && sunset_reg)
                            walk_next = '0;
                        else
                        begin
                            light_next  = '0;
                            active_next = 1'b0;
                        end
                    end
                    REQ_NEXT:
                    begin
                        if (active_reg)
                            end_next = now_reg;
                    end
                    REQ_JUMP:
                    begin
                        rd_en   = 1'b1;
                        rd_addr = tbl_idx({1'b0, idx_reg});
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_START_WB:
            begin
                active_next = 1'b1;
                step_next   = '0;
                start_next  = now_reg;
                end_next    = now_reg + ivl_q;
                origin_next = light_reg;
            end
            ST_JUMP_WB:
            begin
                step_next  = {1'b0, idx_reg};
                start_next = now_reg;
                end_next   = end_reg + ivl_q;
            end
            ST_ADV:
            begin
                if (adv_stop)
                begin
                    step_next   = step_inc[4:0];
                    active_next = 1'b0;
                    light_next  = '0;
                end
                else
                begin
                    step_next = adv_step;
                    rd_en     = 1'b1;
                    rd_addr   = tbl_idx(adv_step);
                end
            end
            ST_ADV_WB:
            begin
                start_next  = now_reg;
                end_next    = end_reg + ivl_q;
                origin_next = light_reg;
            end
            ST_TICK_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = tbl_idx(step_reg);
            end
            ST_TICK_SETUP:
            begin
                tgt_next = tgt_q;
                d_next   = d_cur;
                e_next   = (e_raw > d_cur) ? d_cur : e_raw;
                ch_next  = '0;
                if (d_cur == '0)
                    light_next = tgt_q;
            end
            ST_MUL:
            begin
                prod_next  = 40'(e_reg) * 40'(diff_b);
                up_next    = t_b >= o_b;
                org_b_next = o_b;
            end
            ST_DIV_GO:
            begin
                // product stays below d*256, so its top 32 bits are already below d
                div_req.start    = 1'b1;
                div_req.rem_init = prod_reg[39:8];
                div_req.quo_init = {prod_reg[7:0], 24'd0};
                div_req.divisor  = d_reg;
                div_req.iters    = ITER_W'(8);
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (ch_reg)
                        2'd0:    light_next[23:16] = blend_b;
                        2'd1:    light_next[15:8]  = blend_b;
                        default: light_next[7:0]   = blend_b;
                    endcase
                    ch_next = ch_reg + 2'd1;
                end
            end
            ST_SUN_RD:
            begin
                if (walk_reg >= eff)
                    end_next = now_reg;
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(walk_reg);
                end
            end
            ST_SUN_GO:
            begin
                // x / (100 * 2^i) == (x >> i) / 100, done as a reciprocal multiply
                sun_prod_next = 64'(ivl_q >> walk_reg) * 64'(SPEEDUP_RECIP);
            end
            ST_SUN_WAIT:
            begin
                ivl_we    = 1'b1;
                wr_addr   = IDX_W'(walk_reg);
                ivl_wdata = 32'(sun_prod_reg[63:SPEEDUP_SHIFT]);
                walk_next = walk_reg + 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    // output handshake
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // keyframe memories
    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[wr_addr] <= tgt_in_reg;
        if (ivl_we)
            ivl_mem[wr_addr] <= ivl_wdata;
        if (rd_en)
        begin
            tgt_q <= tgt_mem[rd_addr];
            ivl_q <= ivl_mem[rd_addr];
        end
    end

    // control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            light_reg     <= '0;
            origin_reg    <= '0;
            step_reg      <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            active_reg    <= 1'b0;
            count_reg     <= 5'd1;
            loop_reg      <= 1'b0;
            sunset_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
            walk_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            light_reg     <= light_next;
            origin_reg    <= origin_next;
            step_reg      <= step_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            walk_reg      <= walk_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STEP_COUNT:  count_reg  <= cfg_data[4:0];
                    CFG_LOOP_ENABLE: loop_reg   <= cfg_data[0];
                    CFG_SUNSET_MODE: sunset_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg    <= in_item.req_type;
            now_reg    <= in_item.now_ms;
            idx_reg    <= in_item.entry_index;
            tgt_in_reg <= {in_item.in_red, in_item.in_green, in_item.in_blue};
            ivl_in_reg <= in_item.interval_ms;
        end
        d_reg        <= d_next;
        e_reg        <= e_next;
        tgt_reg      <= tgt_next;
        prod_reg     <= prod_next;
        up_reg       <= up_next;
        org_b_reg    <= org_b_next;
        sun_prod_reg <= sun_prod_next;
        if (out_load)
        begin
            out_item_reg.out_red   <= light_reg[23:16];
            out_item_reg.out_green <= light_reg[15:8];
            out_item_reg.out_blue  <= light_reg[7:0];
            out_item_reg.running   <= active_reg;
            out_item_reg.step_now  <= step_reg[3:0];
        end
    end

endmodule

[tb/tb_top.sv]
// self-checking testbench for the rgb color fade sequencer top level
`timescale 1ns / 100ps

module tb_top;
    import lcfs_pkg::*;

    // request codes that the block must ignore
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam int         DEPTH      = 16;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    led_color_fade_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the sequencer state, kept in step with every accepted item
    logic [23:0] key_color [DEPTH];
    logic [31:0] key_ivl   [DEPTH];
    logic [23:0] lamp;
    logic [23:0] fade_from;
    logic [4:0]  step_idx;
    logic [31:0] t_begin;
    logic [31:0] t_end;
    logic        lit;
    logic [4:0]  reg_steps;
    logic        reg_loop;
    logic        reg_sunset;

    out_item_t   lamp_queue[$];    // expected output items, oldest first

    int n_sent;
    int n_checked;
    int n_bad;
    int n_sunset;
    int n_wraps;
    int hold_cycles;               // receiver hold-off request, in cycles
    bit no_gaps;                   // both sides run flat out while set
    logic [31:0] clock_ms;         // running millisecond timestamp for stimulus

    // clock and run limit
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d items still expected", lamp_queue.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [4:0] live_steps();
        return (reg_steps > DEPTH) ? 5'(DEPTH) : reg_steps;
    endfunction

    // exact floor of org + e*(tgt-org)/d for one channel
    function automatic logic [7:0] fade_chan(logic [7:0] org, logic [7:0] tgt,
                                             longint unsigned e, longint unsigned d);
        longint unsigned num;
        if (tgt >= org)
        begin
            num = e * longint'(tgt - org);
            return org + 8'(num / d);
        end
        num = e * longint'(org - tgt);
        return org - 8'((num + d - 1) / d);
    endfunction

    task automatic step_on(input logic [31:0] now);
        step_idx = step_idx + 1'b1;
        if (step_idx >= live_steps())
        begin
            if (reg_loop)
            begin
                step_idx = '0;
                n_wraps++;
            end
            else
            begin
                lit  = 1'b0;
                lamp = '0;
                return;
            end
        end
        t_begin   = now;
        t_end     = t_end + key_ivl[step_idx[3:0]];
        fade_from = lamp;
    endtask

    task automatic tick_lamp(input logic [31:0] now);
        logic [23:0]     tgt;
        logic [31:0]     span;
        logic [31:0]     gone;
        if (now > t_end)
        begin
            step_on(now);
            if (!lit)
                return;
        end
        tgt  = key_color[step_idx[3:0]];
        span = t_end - t_begin;
        if (span == 0)
        begin
            lamp = tgt;
            return;
        end
        gone = now - t_begin;
        if (gone > span)
            gone = span;
        for (int sh = 16; sh >= 0; sh -= 8)
            lamp[sh +: 8] = fade_chan(fade_from[sh +: 8], tgt[sh +: 8], gone, span);
    endtask

    task automatic predict_lamp(input in_item_t it);
        out_item_t res;
        case (it.req_type)
            REQ_TICK:
                if (lit)
                    tick_lamp(it.now_ms);
            REQ_LOAD:
            begin
                key_color[it.entry_index] = {it.in_red, it.in_green, it.in_blue};
                key_ivl[it.entry_index]   = it.interval_ms;
            end
            REQ_START:
            begin
                lit       = 1'b1;
                step_idx  = '0;
                t_begin   = it.now_ms;
                t_end     = it.now_ms + key_ivl[0];
                fade_from = lamp;
            end
            REQ_STOP:
                if (lit && reg_sunset)
                begin
                    // every live interval is divided by 100 * 2^i
                    for (int i = 0; i < live_steps(); i++)
                        key_ivl[i] = 32'(longint'(key_ivl[i]) / (longint'(100) << i));
                    n_sunset++;
                    t_end = it.now_ms;
                    step_on(it.now_ms);
                end
                else
                begin
                    lamp = '0;
                    lit  = 1'b0;
                end
            REQ_NEXT:
                if (lit)
                begin
                    t_end = it.now_ms;
                    step_on(it.now_ms);
                end
            REQ_JUMP:
                if (lit && it.entry_index < live_steps())
                begin
                    step_idx = it.entry_index;
                    t_begin  = it.now_ms;
                    t_end    = t_end + key_ivl[it.entry_index];
                end
            default: ;
        endcase
        res.out_red   = lamp[23:16];
        res.out_green = lamp[15:8];
        res.out_blue  = lamp[7:0];
        res.running   = lit;
        res.step_now  = step_idx[3:0];
        lamp_queue.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_lamp(it);
        n_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lamp_queue.size() != 0)
            @(posedge clk);
        // margin after the last output item before touching the registers
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_STEP_COUNT:  reg_steps  = val[4:0];
            CFG_LOOP_ENABLE: reg_loop   = val[0];
            CFG_SUNSET_MODE: reg_sunset = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic [4:0] steps, input logic lp, input logic sun);
        wait_idle();
        write_reg(CFG_STEP_COUNT, {3'b000, steps});
        write_reg(CFG_LOOP_ENABLE, {7'd0, lp});
        write_reg(CFG_SUNSET_MODE, {7'd0, sun});
    endtask

    function automatic in_item_t make_item(input logic [2:0] rq, input logic [31:0] now,
                                           input logic [3:0] idx, input logic [23:0] rgb,
                                           input logic [31:0] ivl);
        in_item_t it;
        it.req_type    = rq;
        it.now_ms      = now;
        it.entry_index = idx;
        it.in_red      = rgb[23:16];
        it.in_green    = rgb[15:8];
        it.in_blue     = rgb[7:0];
        it.interval_ms = ivl;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                // long stall so the block backs up into its input
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 13);
            repeat (gap)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lamp_queue.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected output item %p", out_item);
            end
            else
            begin
                want = lamp_queue.pop_front();
                n_checked++;
                if (out_item.out_red !== want.out_red || out_item.out_green !== want.out_green
                    || out_item.out_blue !== want.out_blue
                    || out_item.running !== want.running
                    || out_item.step_now !== want.step_now)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch at item %0d: expected %p got %p",
                                 n_checked, want, out_item);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // fill every table entry first so no read ever hits an unloaded one
    task automatic test_table_fill();
        for (int i = 0; i < DEPTH; i++)
            send_item(make_item(REQ_LOAD, $urandom, 4'(i), 24'($urandom),
                                $urandom_range(0, 60)));
        // color and interval extremes
        send_item(make_item(REQ_LOAD, '0, 4'd0, 24'hFFFFFF, 32'd40));
        send_item(make_item(REQ_LOAD, '1, 4'd1, 24'h000000, 32'd0));
        send_item(make_item(REQ_LOAD, '0, 4'd15, 24'hFF00FF, 32'hFFFFFFFF));
        send_item(make_item(REQ_LOAD, '0, 4'd15, 24'h00FF00, 32'd25));
    endtask

    // every request kind but load, a rising fade, the step end, a wrapping end time, ignored codes
    task automatic test_requests();
        send_item(make_item(REQ_TICK, 32'd5, 4'd0, '0, '0));        // tick while idle
        send_item(make_item(REQ_NEXT, 32'd5, 4'd0, '0, '0));        // next while idle
        send_item(make_item(REQ_JUMP, 32'd5, 4'd0, '0, '0));        // jump while idle
        send_item(make_item(REQ_STOP, 32'd5, 4'd0, '0, '0));        // stop while idle
        send_item(make_item(REQ_START, 32'd100, 4'd0, '0, '0));
        send_item(make_item(REQ_TICK, 32'd113, 4'd0, '0, '0));      // rising fade
        send_item(make_item(REQ_TICK, 32'd140, 4'd0, '0, '0));      // exactly at end
        send_item(make_item(REQ_TICK, 32'd141, 4'd0, '0, '0));      // past end, single step ends
        send_item(make_item(REQ_START, 32'hFFFFFFF0, 4'd0, '0, '0));// end time wraps
        send_item(make_item(REQ_TICK, 32'hFFFFFFF8, 4'd0, '0, '0));
        send_item(make_item(REQ_SPARE6, 32'd1, 4'd3, '1, '1));
        send_item(make_item(REQ_SPARE7, 32'd1, 4'd3, '1, '1));
        send_item(make_item(REQ_STOP, 32'd9, 4'd0, '0, '0));        // blank
    endtask

    task automatic test_steps_and_jumps();
        set_mode(5'd4, 1'b1, 1'b0);
        send_item(make_item(REQ_LOAD, '0, 4'd1, 24'h000000, 32'd0));
        send_item(make_item(REQ_START, 32'd1000, 4'd0, '0, '0));
        send_item(make_item(REQ_TICK, 32'd1041, 4'd0, '0, '0));     // into zero-length step
        send_item(make_item(REQ_JUMP, 32'd1050, 4'd3, '0, '0));
        send_item(make_item(REQ_JUMP, 32'd1051, 4'd9, '0, '0));     // beyond count
        send_item(make_item(REQ_NEXT, 32'd1060, 4'd0, '0, '0));     // wraps to step zero
        send_item(make_item(REQ_TICK, 32'd1070, 4'd0, '0, '0));     // rising fade
        send_item(make_item(REQ_STOP, 32'd1080, 4'd0, '0, '0));
    endtask

    // random traffic, mostly starts and ticks, with a timestamp that runs forward but now and then jumps
    task automatic run_traffic(input int count);
        in_item_t    it;
        int          pick;
        logic [31:0] ivl;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            ivl  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 80);
            clock_ms = clock_ms + $urandom_range(0, 12);
            if ($urandom_range(0, 60) == 0)
                clock_ms = $urandom;
            it = make_item(REQ_TICK, clock_ms, 4'($urandom), 24'($urandom), ivl);
            if (pick < 60)
                it.req_type = lit ? REQ_TICK : REQ_START;
            else if (pick < 70)
                it.req_type = REQ_LOAD;
            else if (pick < 75)
                it.req_type = REQ_START;
            else if (pick < 82)
                it.req_type = REQ_STOP;
            else if (pick < 89)
                it.req_type = REQ_NEXT;
            else if (pick < 97)
                it.req_type = REQ_JUMP;
            else
                it.req_type = pick[0] ? REQ_SPARE6 : REQ_SPARE7;
            send_item(it);
        end
    endtask

    task automatic test_settings();
        logic [4:0] counts [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd7};
        for (int k = 0; k < 6; k++)
        begin
            set_mode(counts[k], k[0], k[1] ^ k[2]);
            no_gaps = (k == 2);
            run_traffic(200);
        end
        no_gaps = 1'b0;
    endtask

    // receiver stalls while items keep coming, the input must back up
    task automatic test_backpressure();
        set_mode(5'd8, 1'b1, 1'b1);
        hold_cycles = 400;
        no_gaps     = 1'b1;
        run_traffic(60);
        no_gaps     = 1'b0;
        run_traffic(100);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        lamp = '0; fade_from = '0; step_idx = '0; t_begin = '0; t_end = '0; lit = 1'b0;
        reg_steps = 5'd1; reg_loop = 1'b0; reg_sunset = 1'b0;
        n_sent = 0; n_checked = 0; n_bad = 0; n_sunset = 0; n_wraps = 0;
        hold_cycles = 0;
        no_gaps     = 1'b0;
        clock_ms    = $urandom;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_fill();
        test_requests();
        test_steps_and_jumps();
        test_settings();
        test_backpressure();
        wait_idle();

        $display("sent %0d items, checked %0d outputs, %0d mismatches", n_sent, n_checked, n_bad);
        $display("covered %0d sunset stops and %0d loop wraps over 8 register settings",
                 n_sunset, n_wraps);
        if (n_bad == 0 && lamp_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[led_color_fade_sequencer_top.f]
hdl/lcfs_pkg.sv
hdl/lcfs_div.sv
hdl/led_color_fade_sequencer_top.sv
tb/tb_top.sv
